// File: src/ctw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int POS_W      = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);

	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [7:0] CODE_BACKSPACE = 8'd8;
	localparam logic [7:0] CODE_NEWLINE   = 8'd10;
	localparam logic [7:0] RESET_ATTR     = 8'h07;

	localparam logic CFG_ATTR   = 1'b0;
	localparam logic CFG_CURSOR = 1'b1;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [COL_W-1:0] col_t;
	typedef logic [15:0]      cell_t;

	localparam pos_t LAST_ROW  = pos_t'(CELL_COUNT - COLUMNS);
	localparam pos_t LAST_CELL = pos_t'(CELL_COUNT - 1);
	localparam pos_t ROW_STEP  = pos_t'(COLUMNS);
	localparam col_t COL_LAST  = col_t'(COLUMNS - 1);

	typedef struct packed {
		logic  we;
		pos_t  waddr;
		cell_t wdata;
		logic  re;
		pos_t  raddr;
	} mem_req_t;

	typedef struct packed {
		logic       done;
		pos_t       pos;
		logic [7:0] rchar;
		logic [7:0] rattr;
	} result_t;

endpackage

`default_nettype wire

// File: src/ctw_cell_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ctw_cell_ram (
	input  wire logic              clk,
	input  wire ctw_pkg::mem_req_t req,
	output ctw_pkg::cell_t         rdata
);

	ctw_pkg::cell_t mem [ctw_pkg::CELL_COUNT];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/ctw_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module ctw_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        kind,
	input  wire logic [7:0]        char_code,
	input  wire logic [10:0]       cell_address,
	input  wire logic [7:0]        attr,
	input  wire ctw_pkg::cell_t    rdata,
	output ctw_pkg::mem_req_t      mreq,
	output ctw_pkg::result_t       res,
	output logic                   busy
);

	localparam logic [2:0] S_INIT    = 3'd0;
	localparam logic [2:0] S_IDLE    = 3'd1;
	localparam logic [2:0] S_FILL    = 3'd2;
	localparam logic [2:0] S_SCROLL  = 3'd3;
	localparam logic [2:0] S_BS_RD   = 3'd4;
	localparam logic [2:0] S_BS_CHK  = 3'd5;
	localparam logic [2:0] S_RD_WAIT = 3'd6;

	logic [2:0]    state_q;
	ctw_pkg::pos_t cnt_q;
	ctw_pkg::pos_t pos_q;
	ctw_pkg::col_t col_q;
	logic          done_q;
	logic [7:0]    rchar_q;
	logic [7:0]    rattr_q;

	logic          accept;
	logic          in_range;
	ctw_pkg::pos_t line_start;
	ctw_pkg::col_t col_next;
	ctw_pkg::col_t col_prev;
	logic          bs_hit;

	assign accept     = start && (state_q == S_IDLE);
	assign in_range   = 32'(cell_address) < ctw_pkg::CELL_COUNT;
	assign line_start = pos_q - ctw_pkg::pos_t'(col_q);
	assign col_next   = (col_q == ctw_pkg::COL_LAST) ? '0 : col_q + 1'b1;
	assign col_prev   = (col_q == '0) ? ctw_pkg::COL_LAST : col_q - 1'b1;
	assign bs_hit     = (rdata[7:0] != 8'h00) || (cnt_q == '0);
	assign busy       = (state_q != S_IDLE);

	always_comb begin
		mreq = '0;
		case (state_q)
			S_INIT: begin
				mreq.we    = 1'b1;
				mreq.waddr = cnt_q;
				mreq.wdata = {ctw_pkg::RESET_ATTR, 8'h00};
			end
			S_FILL: begin
				mreq.we    = 1'b1;
				mreq.waddr = cnt_q;
				mreq.wdata = {attr, 8'h00};
			end
			S_SCROLL: begin
				mreq.re    = (cnt_q != ctw_pkg::LAST_ROW);
				mreq.raddr = cnt_q + ctw_pkg::ROW_STEP;
				mreq.we    = (cnt_q != '0);
				mreq.waddr = cnt_q - 1'b1;
				mreq.wdata = rdata;
			end
			S_BS_RD: begin
				mreq.re    = 1'b1;
				mreq.raddr = cnt_q;
			end
			S_BS_CHK: begin
				mreq.we    = bs_hit;
				mreq.waddr = cnt_q;
				mreq.wdata = {attr, 8'h00};
			end
			S_IDLE: begin
				if (accept && kind == ctw_pkg::KIND_PUT) begin
					if (char_code == ctw_pkg::CODE_BACKSPACE) begin
						mreq.we    = (pos_q == '0);
						mreq.waddr = '0;
						mreq.wdata = {attr, 8'h00};
					end else if (char_code != ctw_pkg::CODE_NEWLINE) begin
						mreq.we    = 1'b1;
						mreq.waddr = pos_q;
						mreq.wdata = {attr, char_code};
					end
				end else if (accept && kind == ctw_pkg::KIND_READ) begin
					mreq.re    = in_range;
					mreq.raddr = ctw_pkg::pos_t'(cell_address);
				end
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q   <= '0;
			pos_q   <= '0;
			col_q   <= '0;
			done_q  <= 1'b0;
			rchar_q <= '0;
			rattr_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ctw_pkg::LAST_CELL) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						rchar_q <= '0;
						rattr_q <= '0;
						case (kind)
							ctw_pkg::KIND_PUT: begin
								if (char_code == ctw_pkg::CODE_NEWLINE) begin
									if (line_start == ctw_pkg::LAST_ROW) begin
										cnt_q   <= '0;
										pos_q   <= ctw_pkg::LAST_ROW;
										col_q   <= '0;
										state_q <= S_SCROLL;
									end else begin
										pos_q  <= line_start + ctw_pkg::ROW_STEP;
										col_q  <= '0;
										done_q <= 1'b1;
									end
								end else if (char_code == ctw_pkg::CODE_BACKSPACE) begin
									if (pos_q == '0) begin
										done_q <= 1'b1;
									end else begin
										cnt_q   <= pos_q - 1'b1;
										col_q   <= col_prev;
										state_q <= S_BS_RD;
									end
								end else begin
									if (pos_q == ctw_pkg::LAST_CELL) begin
										cnt_q   <= '0;
										pos_q   <= ctw_pkg::LAST_ROW;
										col_q   <= '0;
										state_q <= S_SCROLL;
									end else begin
										pos_q  <= pos_q + 1'b1;
										col_q  <= col_next;
										done_q <= 1'b1;
									end
								end
							end
							ctw_pkg::KIND_CLEAR: begin
								cnt_q   <= '0;
								pos_q   <= '0;
								col_q   <= '0;
								state_q <= S_FILL;
							end
							ctw_pkg::KIND_READ: begin
								if (in_range) begin
									state_q <= S_RD_WAIT;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ctw_pkg::LAST_CELL) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SCROLL: begin
					if (cnt_q == ctw_pkg::LAST_ROW) begin
						state_q <= S_FILL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_BS_RD: begin
					state_q <= S_BS_CHK;
				end
				S_BS_CHK: begin
					if (bs_hit) begin
						pos_q   <= cnt_q;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						col_q   <= col_prev;
						state_q <= S_BS_RD;
					end
				end
				S_RD_WAIT: begin
					rchar_q <= rdata[7:0];
					rattr_q <= rdata[15:8];
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.done  = done_q;
	assign res.pos   = pos_q;
	assign res.rchar = rchar_q;
	assign res.rattr = rattr_q;

endmodule

`default_nettype wire

// File: src/text_console_char_writer_top.sv
// Text console cell writer over an 80 x 25 store of character/attribute cells.
// Request channel: raise start with kind, char_code and cell_address; the
// request is taken at a clock edge where start is high and busy is low.
// Result channel: done pulses for one cycle with cursor_index, cursor_shown,
// read_char and read_attr; the receiver cannot stall, so it must take every
// result in that cycle.
// Configuration: cfg_write with cfg_index 0 sets the text attribute, index 1
// the cursor enable; write only while busy is low and no result is pending.
// Steps from accept to done:
//   printed character, newline without scroll or unused kind: done is registered at accept
//   read of one cell: a memory read, then the wait state; no read past the last cell
//   backspace: a read and a check state per cell scanned back, none at cell 0
//   scroll (put past the last cell): each cell moved up a row, then the last row blanked
//   clear screen: every cell blanked in turn
// Long operations are set by the single write port of the cell memory, which
// moves or blanks one cell per cycle. One request is in work at a time.
// Reset: the block sweeps the whole store to blank cells with attribute 07h,
// holding busy high while it lasts; configuration is taken during the sweep.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  char_code,
	input  wire logic [10:0] cell_address,
	output logic             done,
	output logic [10:0]      cursor_index,
	output logic             cursor_shown,
	output logic [7:0]       read_char,
	output logic [7:0]       read_attr,
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	logic [7:0]        attr_q;
	logic              cen_q;
	ctw_pkg::mem_req_t mreq;
	ctw_pkg::cell_t    rdata;
	ctw_pkg::result_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ctw_pkg::RESET_ATTR;
			cen_q  <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				ctw_pkg::CFG_ATTR:   attr_q <= cfg_data;
				ctw_pkg::CFG_CURSOR: cen_q  <= cfg_data[0];
				default:             attr_q <= attr_q;
			endcase
		end
	end

	ctw_cell_ram u_ram (
		.clk   (clk),
		.req   (mreq),
		.rdata (rdata)
	);

	ctw_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.kind         (kind),
		.char_code    (char_code),
		.cell_address (cell_address),
		.attr         (attr_q),
		.rdata        (rdata),
		.mreq         (mreq),
		.res          (res),
		.busy         (busy)
	);

	assign done         = res.done;
	assign cursor_shown = cen_q && (32'(res.pos) <= 32'h7FF);
	assign cursor_index = cen_q ? 11'(res.pos) : '0;
	assign read_char    = res.rchar;
	assign read_attr    = res.rattr;

endmodule

`default_nettype wire

// File: src/ctw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ctw_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [1:0]  kind,
	input wire logic        done,
	input wire logic [10:0] cursor_index,
	input wire logic        cursor_shown,
	input wire logic [7:0]  read_char,
	input wire logic [7:0]  read_attr
);

	// hold busy or answer right after a request
	a_accept_followed: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("request dropped");

	// drop no result without a request behind it
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start && !busy)))
		else $error("result without request");

	a_cursor_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !cursor_shown) |-> (cursor_index == 11'd0))
		else $error("hidden cursor reports index");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cursor_shown) |-> (32'(cursor_index) < ctw_pkg::CELL_COUNT))
		else $error("cursor outside screen");

	a_no_read_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && !busy && kind != ctw_pkg::KIND_READ))
		|-> (read_char == 8'd0 && read_attr == 8'd0))
		else $error("cell data on non-read result");

endmodule

bind text_console_char_writer_top ctw_checker u_ctw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.kind         (kind),
	.done         (done),
	.cursor_index (cursor_index),
	.cursor_shown (cursor_shown),
	.read_char    (read_char),
	.read_attr    (read_attr)
);

`default_nettype wire

// File: verif/tb_text_console_char_writer_top.sv
`timescale 1ns / 1ps

module tb_text_console_char_writer_top;
	import ctw_pkg::*;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [10:0] idx;
		logic        shown;
		logic [7:0]  rchar;
		logic [7:0]  rattr;
	} console_result_t;

	typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_op_t;

	typedef struct packed {
		row_op_t         op;
		logic [1:0]      kind;
		logic [7:0]      code;
		logic [10:0]     addr;
		logic            reg_sel;
		logic [7:0]      reg_val;
		logic            typed;
		console_result_t want;
	} stim_row_t;

	localparam stim_row_t DIRECTED_ROWS [25] = '{
		'{ROW_REQUEST, KIND_READ, 8'h00, 11'd0, CFG_ATTR, 8'h00, 1'b1,
			'{11'd0, 1'b1, 8'h00, 8'h07}},
		'{ROW_REQUEST, KIND_READ, 8'h00, LAST_CELL, CFG_ATTR, 8'h00, 1'b1,
			'{11'd0, 1'b1, 8'h00, 8'h07}},
		'{ROW_REQUEST, KIND_READ, 8'hFF, 11'h7FF, CFG_ATTR, 8'h00, 1'b1,
			'{11'd0, 1'b1, 8'h00, 8'h00}},
		'{ROW_REQUEST, KIND_SPARE, 8'hFF, 11'h7FF, CFG_ATTR, 8'h00, 1'b1,
			'{11'd0, 1'b1, 8'h00, 8'h00}},
		'{ROW_REQUEST, KIND_PUT, CODE_BACKSPACE, 11'd0, CFG_ATTR, 8'h00, 1'b1,
			'{11'd0, 1'b1, 8'h00, 8'h00}},
		'{ROW_REQUEST, KIND_PUT, 8'h41, 11'd0, CFG_ATTR, 8'h00, 1'b1,
			'{11'd1, 1'b1, 8'h00, 8'h00}},
		'{ROW_REQUEST, KIND_READ, 8'h00, 11'd0, CFG_ATTR, 8'h00, 1'b0, '0},
		'{ROW_CONFIG, KIND_PUT, 8'h00, 11'd0, CFG_ATTR, 8'hFF, 1'b0, '0},
		'{ROW_REQUEST, KIND_PUT, 8'hFF, 11'd0, CFG_ATTR, 8'h00, 1'b1,
			'{11'd2, 1'b1, 8'h00, 8'h00}},
		'{ROW_REQUEST, KIND_PUT, 8'h00, 11'd0, CFG_ATTR, 8'h00, 1'b1,
			'{11'd3, 1'b1, 8'h00, 8'h00}},
		'{ROW_REQUEST, KIND_READ, 8'h00, 11'd2, CFG_ATTR, 8'h00, 1'b0, '0},
		'{ROW_REQUEST, KIND_PUT, CODE_NEWLINE, 11'd0, CFG_ATTR, 8'h00, 1'b1,
			'{11'd80, 1'b1, 8'h00, 8'h00}},
		'{ROW_REQUEST, KIND_PUT, CODE_BACKSPACE, 11'd0, CFG_ATTR, 8'h00, 1'b0, '0},
		'{ROW_REQUEST, KIND_PUT, CODE_BACKSPACE, 11'd0, CFG_ATTR, 8'h00, 1'b0, '0},
		'{ROW_REQUEST, KIND_PUT, CODE_NEWLINE, 11'd0, CFG_ATTR, 8'h00, 1'b1,
			'{11'd80, 1'b1, 8'h00, 8'h00}},
		'{ROW_REQUEST, KIND_PUT, CODE_BACKSPACE, 11'd0, CFG_ATTR, 8'h00, 1'b0, '0},
		'{ROW_REQUEST, KIND_READ, 8'h00, 11'd0, CFG_ATTR, 8'h00, 1'b0, '0},
		'{ROW_CONFIG, KIND_PUT, 8'h00, 11'd0, CFG_CURSOR, 8'hFE, 1'b0, '0},
		'{ROW_REQUEST, KIND_READ, 8'h00, 11'd3, CFG_ATTR, 8'h00, 1'b0, '0},
		'{ROW_REQUEST, KIND_PUT, 8'h7E, 11'd0, CFG_ATTR, 8'h00, 1'b0, '0},
		'{ROW_CONFIG, KIND_PUT, 8'h00, 11'd0, CFG_ATTR, 8'h00, 1'b0, '0},
		'{ROW_REQUEST, KIND_CLEAR, 8'h00, 11'd0, CFG_ATTR, 8'h00, 1'b1,
			'{11'd0, 1'b0, 8'h00, 8'h00}},
		'{ROW_REQUEST, KIND_READ, 8'h00, LAST_CELL, CFG_ATTR, 8'h00, 1'b1,
			'{11'd0, 1'b0, 8'h00, 8'h00}},
		'{ROW_CONFIG, KIND_PUT, 8'h00, 11'd0, CFG_CURSOR, 8'h01, 1'b0, '0},
		'{ROW_REQUEST, KIND_READ, 8'h00, 11'(CELL_COUNT), CFG_ATTR, 8'h00, 1'b1,
			'{11'd0, 1'b1, 8'h00, 8'h00}}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [7:0]  char_code;
	logic [10:0] cell_address;
	logic        done;
	logic [10:0] cursor_index;
	logic        cursor_shown;
	logic [7:0]  read_char;
	logic [7:0]  read_attr;
	logic        cfg_write;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	logic [7:0] screen_char [CELL_COUNT];
	logic [7:0] screen_attr [CELL_COUNT];
	int         cursor_pos;
	logic [7:0] text_attr;
	logic       cursor_on;

	console_result_t pending_results [$];
	console_result_t oldest;
	int              mismatch_count = 0;
	int              sender_idle_pct = 35;
	int              quiet_cycles = 0;

	text_console_char_writer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.char_code    (char_code),
		.cell_address (cell_address),
		.done         (done),
		.cursor_index (cursor_index),
		.cursor_shown (cursor_shown),
		.read_char    (read_char),
		.read_attr    (read_attr),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic console_result_t advance_console(input logic [1:0] k,
			input logic [7:0] c, input logic [10:0] a);
		console_result_t r;
		int p;
		r = '0;
		case (k)
			KIND_PUT: begin
				p = cursor_pos;
				if (c == CODE_NEWLINE) begin
					p += COLUMNS - (p % COLUMNS);
				end else if (c == CODE_BACKSPACE) begin
					if (p > 0) begin
						do p--; while (p > 0 && screen_char[p] == 8'h00);
					end
					screen_char[p] = 8'h00;
					screen_attr[p] = text_attr;
				end else begin
					screen_char[p] = c;
					screen_attr[p] = text_attr;
					p++;
				end
				if (p >= CELL_COUNT) begin
					for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
						screen_char[i] = screen_char[i + COLUMNS];
						screen_attr[i] = screen_attr[i + COLUMNS];
					end
					for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
						screen_char[i] = 8'h00;
						screen_attr[i] = text_attr;
					end
					p = CELL_COUNT - COLUMNS;
				end
				cursor_pos = p;
			end
			KIND_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++) begin
					screen_char[i] = 8'h00;
					screen_attr[i] = text_attr;
				end
				cursor_pos = 0;
			end
			KIND_READ: begin
				if (a < CELL_COUNT) begin
					r.rchar = screen_char[a];
					r.rattr = screen_attr[a];
				end
			end
			default: ;
		endcase
		if (cursor_on) begin
			r.idx   = 11'(cursor_pos);
			r.shown = 1'b1;
		end
		return r;
	endfunction

	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0 || busy !== 1'b0);
	endtask

	task automatic write_register(input logic sel, input logic [7:0] val);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (sel == CFG_ATTR)
			text_attr = val;
		else
			cursor_on = val[0];
	endtask

	task automatic send_request(input logic [1:0] k, input logic [7:0] c,
			input logic [10:0] a, input logic typed, input console_result_t want);
		console_result_t predicted;
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		start        <= 1'b1;
		kind         <= k;
		char_code    <= c;
		cell_address <= a;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = advance_console(k, c, a);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic run_phase(input int idle_pct, input logic [7:0] attr,
			input logic [7:0] cursor_val, input int count);
		int          pick;
		int          newline_run;
		logic [1:0]  k;
		logic [7:0]  c;
		logic [10:0] a;
		newline_run = 0;
		write_register(CFG_ATTR, attr);
		write_register(CFG_CURSOR, cursor_val);
		sender_idle_pct = idle_pct;
		for (int n = 0; n < count; n++) begin
			k = KIND_PUT;
			c = 8'($urandom);
			a = 11'($urandom);
			pick = $urandom_range(0, 99);
			if (newline_run > 0) begin
				c = CODE_NEWLINE;
				newline_run--;
			end else if (pick < 4) begin
				// run of newlines to reach the bottom row and scroll
				c = CODE_NEWLINE;
				newline_run = $urandom_range(4, 29);
			end else if (pick < 46) begin
			end else if (pick < 60) begin
				c = CODE_NEWLINE;
			end else if (pick < 73) begin
				c = CODE_BACKSPACE;
			end else if (pick < 95) begin
				k = KIND_READ;
				pick = $urandom_range(0, 9);
				if (pick < 6)
					a = 11'(cursor_pos - $urandom_range(0, cursor_pos < 160 ? cursor_pos : 160));
				else if (pick < 8)
					a = 11'($urandom_range(0, CELL_COUNT - 1));
			end else if (pick < 97) begin
				k = KIND_CLEAR;
			end else begin
				k = KIND_SPARE;
			end
			send_request(k, c, a, 1'b0, '0);
		end
	endtask

	task automatic check_field(input string name, input logic [10:0] want,
			input logic [10:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		if (done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result cursor_index=%0d read_char=%0h read_attr=%0h",
					$time, cursor_index, read_char, read_attr);
				mismatch_count++;
			end else begin
				oldest = pending_results.pop_front();
				check_field("cursor_index", oldest.idx, cursor_index);
				check_field("cursor_shown", 11'(oldest.shown), 11'(cursor_shown));
				check_field("read_char", 11'(oldest.rchar), 11'(read_char));
				check_field("read_attr", 11'(oldest.rattr), 11'(read_attr));
			end
		end
	end

	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("text_console_char_writer_top test failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		stim_row_t row;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		kind         <= KIND_PUT;
		char_code    <= 8'h00;
		cell_address <= 11'd0;
		cfg_write    <= 1'b0;
		cfg_index    <= CFG_ATTR;
		cfg_data     <= 8'h00;
		foreach (screen_char[i]) begin
			screen_char[i] = 8'h00;
			screen_attr[i] = RESET_ATTR;
		end
		cursor_pos = 0;
		text_attr  = RESET_ATTR;
		cursor_on  = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_ROWS[i]) begin
			row = DIRECTED_ROWS[i];
			if (row.op == ROW_CONFIG)
				write_register(row.reg_sel, row.reg_val);
			else
				send_request(row.kind, row.code, row.addr, row.typed, row.want);
		end

		run_phase(35, 8'($urandom_range(1, 254)), 8'h01, 100);
		// hold the cursor hidden with the upper data bits set
		run_phase(75, 8'h00, 8'hFE, 40);
		run_phase(75, 8'hFF, 8'h01, 60);
		run_phase(0, 8'($urandom), {7'($urandom), 1'b1}, 100);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("text_console_char_writer_top test passed");
		else
			$display("text_console_char_writer_top test failed");
		$finish;
	end

endmodule
